/* hw/rtl/rmse_pkg.sv */
// Package for the register mask set engine: word types, codes and set helpers.
package rmse_pkg;

	localparam int MASK_WORDS_DEF = 8;
	localparam int WORD_W = 32;
	localparam int CFG_DATA_W = 3;

	typedef enum logic [0:0] {
		CFG_SET_SIZE = 1'b0,
		CFG_MODE     = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_SMEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_ONE   = 2'd1,
		PH_SPLIT = 2'd2,
		PH_FAIL  = 2'd3
	} bound_phase_t;

	typedef struct packed {
		logic [31:0] mask_word;
		logic        last_word;
	} src_word_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        end_of_mask;
		logic [8:0]  bit_count;
		logic        aligned_ok;
		logic        bound_ok;
		logic        first_found;
		logic [8:0]  first_reg;
	} res_word_t;

	function automatic logic [2:0] clamp_log(input logic [2:0] lg);
		return (lg > 3'd4) ? 3'd4 : lg;
	endfunction

	// keep aligned groups that are full (clear) or nonempty (smear)
	function automatic logic [31:0] sets_of(input logic [31:0] w, input logic [2:0] lg,
			input logic smear);
		logic [31:0] res;
		logic        keep;
		res = w;
		case (lg)
			3'd1: begin
				for (int g = 0; g < 16; g++) begin
					keep = smear ? (|w[2*g +: 2]) : (&w[2*g +: 2]);
					res[2*g +: 2] = {2{keep}};
				end
			end
			3'd2: begin
				for (int g = 0; g < 8; g++) begin
					keep = smear ? (|w[4*g +: 4]) : (&w[4*g +: 4]);
					res[4*g +: 4] = {4{keep}};
				end
			end
			3'd3: begin
				for (int g = 0; g < 4; g++) begin
					keep = smear ? (|w[8*g +: 8]) : (&w[8*g +: 8]);
					res[8*g +: 8] = {8{keep}};
				end
			end
			3'd4: begin
				for (int g = 0; g < 2; g++) begin
					keep = smear ? (|w[16*g +: 16]) : (&w[16*g +: 16]);
					res[16*g +: 16] = {16{keep}};
				end
			end
			default: res = w;
		endcase
		return res;
	endfunction

	function automatic logic [4:0] lowest_bit(input logic [31:0] w);
		logic [4:0] p;
		p = 5'd31;
		for (int i = 31; i >= 0; i--) begin
			if (w[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

/* hw/rtl/register_mask_set_engine.sv */
// Top level of the register mask set engine: word transform and mask summary.
//
//  channel | direction | handshake             | payload
//  src     | in        | src_valid / src_stall | src_data  (mask_word, last_word)
//  dst     | out       | dst_valid / dst_stall | dst_data  (out_word and summary)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle sustained while the result is not stalled; a word passes
// the input register, then one pass of popcount, priority encode and set masks
// into the result register, where the running mask state is updated.
// Reset clears the running state and loads set_size_log 1, transform_mode 0.
// A stalled result holds; the input register still takes one more word.
module register_mask_set_engine #(
	parameter int MASK_WORDS = rmse_pkg::MASK_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  rmse_pkg::src_word_t           src_data,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output rmse_pkg::res_word_t           dst_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  rmse_pkg::cfg_index_t          cfg_index,
	input  logic [rmse_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rmse_pkg::*;

	localparam int WPW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

	logic [2:0]      set_size_log_q;
	logic [1:0]      transform_mode_q;

	src_word_t       word_s1;
	logic            valid_s1;
	logic            advance;

	logic [WPW-1:0]  word_pos_q;
	logic [8:0]      bit_total_q;
	logic            aligned_q;
	bound_phase_t    phase_q;
	logic [15:0]     expect_q;
	logic            first_seen_q;
	logic [8:0]      first_pos_q;

	res_word_t       dst_data_q;
	logic            dst_valid_q;

	logic [31:0]     w;
	logic [2:0]      lg;
	logic [4:0]      size;
	logic [31:0]     ow;
	logic            last_eff;
	logic [4:0]      p;
	logic [8:0]      bit_total_n;
	logic            aligned_n;
	bound_phase_t    phase_n;
	logic [15:0]     expect_n;
	logic            first_seen_n;
	logic [8:0]      first_pos_n;
	logic [15:0]     grp;
	logic            fits;
	logic [5:0]      q6;
	logic [3:0]      q;
	res_word_t       res_n;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!dst_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_log_q   <= 3'd1;
			transform_mode_q <= MODE_PASS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_SIZE: set_size_log_q <= cfg_data[2:0];
				CFG_MODE:     transform_mode_q <= cfg_data[1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_data;
		end
	end

	always_comb begin
		w        = word_s1.mask_word;
		lg       = clamp_log(set_size_log_q);
		size     = 5'd1 << lg;
		last_eff = word_s1.last_word || (word_pos_q == WPW'(MASK_WORDS - 1));
		p        = lowest_bit(w);

		case (transform_mode_q)
			MODE_CLEAR: ow = sets_of(w, lg, 1'b0);
			MODE_SMEAR: ow = sets_of(w, lg, 1'b1);
			default:    ow = w;
		endcase

		bit_total_n = bit_total_q + 9'($countones(w));
		aligned_n   = aligned_q && (sets_of(w, lg, 1'b0) == w);

		grp      = 16'((17'd1 << size) - 17'd1);
		fits     = (6'(p) + 6'(size)) <= 6'd32;
		q6       = 6'(p) + 6'(size) - 6'd32;
		q        = q6[3:0];
		phase_n  = phase_q;
		expect_n = expect_q;
		case (phase_q)
			PH_SPLIT: phase_n = (w == {16'b0, expect_q}) ? PH_ONE : PH_FAIL;
			PH_ONE: begin
				if (w != '0) begin
					phase_n = PH_FAIL;
				end
			end
			PH_NONE: begin
				if (w != '0) begin
					if (fits) begin
						phase_n = (w == ({16'b0, grp} << p)) ? PH_ONE : PH_FAIL;
					end else if (w == (32'hFFFF_FFFF << p)) begin
						expect_n = 16'((17'd1 << q) - 17'd1);
						phase_n  = PH_SPLIT;
					end else begin
						phase_n = PH_FAIL;
					end
				end
			end
			default: phase_n = PH_FAIL;
		endcase

		first_seen_n = first_seen_q;
		first_pos_n  = first_pos_q;
		if (!first_seen_q && (w != '0)) begin
			first_seen_n = 1'b1;
			first_pos_n  = 9'({word_pos_q, 5'b0}) + 9'(p);
		end

		res_n          = '0;
		res_n.out_word = ow;
		if (last_eff) begin
			res_n.end_of_mask = 1'b1;
			res_n.bit_count   = bit_total_n;
			res_n.aligned_ok  = aligned_n;
			res_n.bound_ok    = ((phase_n == PH_NONE) || (phase_n == PH_ONE)) && !w[31];
			res_n.first_found = first_seen_n;
			res_n.first_reg   = first_seen_n ? (first_pos_n + 9'(size) - 9'd1) : 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q   <= '0;
			bit_total_q  <= '0;
			aligned_q    <= 1'b1;
			phase_q      <= PH_NONE;
			expect_q     <= '0;
			first_seen_q <= 1'b0;
			first_pos_q  <= '0;
		end else if (advance) begin
			if (last_eff) begin
				word_pos_q   <= '0;
				bit_total_q  <= '0;
				aligned_q    <= 1'b1;
				phase_q      <= PH_NONE;
				expect_q     <= '0;
				first_seen_q <= 1'b0;
				first_pos_q  <= '0;
			end else begin
				word_pos_q   <= word_pos_q + WPW'(1);
				bit_total_q  <= bit_total_n;
				aligned_q    <= aligned_n;
				phase_q      <= phase_n;
				expect_q     <= expect_n;
				first_seen_q <= first_seen_n;
				first_pos_q  <= first_pos_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (advance) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dst_data_q <= res_n;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_pos_q <= WPW'(MASK_WORDS - 1))
		else $error("word position beyond mask length");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_eff |=> (word_pos_q == '0) && (bit_total_q == '0) && !first_seen_q)
		else $error("running state not cleared after final word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && dst_valid_q && dst_stall)
		else $error("input stalled without a blocked result");

	a_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.end_of_mask |->
			(dst_data.bit_count == '0) && !dst_data.first_found && (dst_data.first_reg == '0))
		else $error("summary fields set on a word that does not end the mask");

	a_empty_mask: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.end_of_mask && !dst_data.first_found |->
			(dst_data.bit_count == '0) && dst_data.aligned_ok && dst_data.bound_ok)
		else $error("empty mask summary inconsistent");

endmodule

/* tb/sv/register_mask_set_engine_tb.sv */
// Self-checking testbench for the register mask set engine: directed table, random masks, scoreboard.
`timescale 1ns / 1ps

module register_mask_set_engine_tb;
	import rmse_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_WORDS = 1200;
	localparam int SQUEEZE_CYCLES = 300;
	localparam logic [2:0] MODE_SPARE = 3'd3;
	localparam src_word_t NO_WORD = '0;
	localparam res_word_t NO_RES = '0;

	typedef struct packed {
		logic        is_cfg;
		cfg_index_t  idx;
		logic [2:0]  val;
		src_word_t   word;
		logic        typed;
		res_word_t   fixed_res;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [26] = '{
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b1}, 1'b1,
			'{32'h0000_0000, 1'b1, 9'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'hFFFF_FFFF, 1'b1}, 1'b1,
			'{32'hFFFF_FFFF, 1'b1, 9'd32, 1'b1, 1'b0, 1'b1, 9'd1}},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0003, 1'b1}, 1'b1,
			'{32'h0000_0003, 1'b1, 9'd2, 1'b1, 1'b1, 1'b1, 9'd1}},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h8000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0001, 1'b1}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h8000_0000, 1'b1}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0C00, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h4000_0000, 1'b0}, 1'b0, NO_RES},
		'{1'b1, CFG_MODE, 3'(MODE_CLEAR), NO_WORD, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0F07, 1'b1}, 1'b0, NO_RES},
		'{1'b1, CFG_MODE, 3'(MODE_SMEAR), NO_WORD, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0001_2400, 1'b1}, 1'b0, NO_RES},
		'{1'b1, CFG_MODE, MODE_SPARE, NO_WORD, 1'b0, NO_RES},
		'{1'b1, CFG_SET_SIZE, 3'd0, NO_WORD, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_0010, 1'b0}, 1'b0, NO_RES},
		'{1'b1, CFG_SET_SIZE, 3'd7, NO_WORD, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'hFFFF_0000, 1'b1}, 1'b0, NO_RES},
		'{1'b1, CFG_SET_SIZE, 3'd4, NO_WORD, 1'b0, NO_RES},
		'{1'b0, CFG_SET_SIZE, 3'd0, '{32'h0000_FFFF, 1'b1}, 1'b0, NO_RES},
		'{1'b1, CFG_MODE, 3'(MODE_PASS), NO_WORD, 1'b0, NO_RES}
	};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	src_word_t  src_data = '0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	res_word_t  dst_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = CFG_SET_SIZE;
	logic [2:0] cfg_data = '0;

	bit calm = 1'b0;
	bit squeeze = 1'b0;
	int mismatches = 0;
	res_word_t mask_results [$];

	logic [2:0]   cur_log = 3'd1;
	logic [1:0]   cur_mode = MODE_PASS;
	int           mword_idx = 0;
	int           ones_total = 0;
	bit           whole_sets = 1'b1;
	bound_phase_t bnd_ph = PH_NONE;
	logic [31:0]  split_low = '0;
	bit           lead_seen = 1'b0;
	int           lead_pos = 0;

	register_mask_set_engine dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] group_fill(logic [31:0] w, int sz, bit smear);
		logic [31:0] grp;
		logic [31:0] part;
		logic [31:0] res;
		grp = 32'((64'd1 << sz) - 64'd1);
		res = '0;
		for (int pos = 0; pos < 32; pos += sz) begin
			part = (w >> pos) & grp;
			if (smear ? (part != 0) : (part == grp)) res |= grp << pos;
		end
		return res;
	endfunction

	function automatic int low_index(logic [31:0] w);
		int p;
		p = 0;
		while (p < 31 && !w[p]) p++;
		return p;
	endfunction

	function automatic int set_len();
		return 1 << ((cur_log > 3'd4) ? 4 : int'(cur_log));
	endfunction

	function automatic res_word_t predict_word(src_word_t sw);
		logic [31:0] w;
		int          sz;
		int          p;
		res_word_t   r;
		w = sw.mask_word;
		sz = set_len();
		p = low_index(w);
		r = '0;
		case (cur_mode)
			MODE_CLEAR: r.out_word = group_fill(w, sz, 1'b0);
			MODE_SMEAR: r.out_word = group_fill(w, sz, 1'b1);
			default:    r.out_word = w;
		endcase
		ones_total += $countones(w);
		if (group_fill(w, sz, 1'b0) != w) whole_sets = 1'b0;
		if (bnd_ph == PH_SPLIT) begin
			bnd_ph = (w == split_low) ? PH_ONE : PH_FAIL;
		end else if (bnd_ph != PH_FAIL && w != 0) begin
			if (bnd_ph == PH_ONE) begin
				bnd_ph = PH_FAIL;
			end else if (p + sz <= 32) begin
				bnd_ph = (w == 32'(((64'd1 << sz) - 64'd1) << p)) ? PH_ONE : PH_FAIL;
			end else if (w == (32'hFFFF_FFFF << p)) begin
				split_low = (32'd1 << (p + sz - 32)) - 32'd1;
				bnd_ph = PH_SPLIT;
			end else begin
				bnd_ph = PH_FAIL;
			end
		end
		if (!lead_seen && w != 0) begin
			lead_seen = 1'b1;
			lead_pos = mword_idx * 32 + p;
		end
		if (sw.last_word || mword_idx >= MASK_WORDS_DEF - 1) begin
			r.end_of_mask = 1'b1;
			r.bit_count = 9'(ones_total);
			r.aligned_ok = whole_sets;
			r.bound_ok = (bnd_ph == PH_NONE || bnd_ph == PH_ONE) && !w[31];
			r.first_found = lead_seen;
			r.first_reg = lead_seen ? 9'(lead_pos + sz - 1) : 9'd0;
			mword_idx = 0;
			ones_total = 0;
			whole_sets = 1'b1;
			bnd_ph = PH_NONE;
			split_low = '0;
			lead_seen = 1'b0;
			lead_pos = 0;
		end else begin
			mword_idx++;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s mismatch, got %h want %h", $time, field, got, want);
	endtask

	task automatic push_word(src_word_t w, bit typed, res_word_t fixed_res, int gap);
		res_word_t guess;
		src_data <= w;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		guess = predict_word(w);
		mask_results.push_back(typed ? fixed_res : guess);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_index_t idx, logic [2:0] val);
		src_valid <= 1'b0;
		while (mask_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SET_SIZE) cur_log = val;
		else cur_mode = val[1:0];
	endtask

	// receiver: random stall, one long hold-off, scoreboard
	initial begin : drain
		int        run_left;
		int        squeeze_left;
		bit        hold;
		bit        squeezed;
		res_word_t want;
		run_left = 0;
		squeeze_left = 0;
		hold = 1'b0;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			if (dst_valid && !dst_stall) begin
				if (mask_results.size() == 0) begin
					flag_mismatch("word with none pending", dst_data.out_word, '0);
				end else begin
					want = mask_results.pop_front();
					if (dst_data.out_word !== want.out_word)
						flag_mismatch("out_word", dst_data.out_word, want.out_word);
					if (dst_data.end_of_mask !== want.end_of_mask)
						flag_mismatch("end_of_mask", 32'(dst_data.end_of_mask),
							32'(want.end_of_mask));
					if (dst_data.bit_count !== want.bit_count)
						flag_mismatch("bit_count", 32'(dst_data.bit_count),
							32'(want.bit_count));
					if (dst_data.aligned_ok !== want.aligned_ok)
						flag_mismatch("aligned_ok", 32'(dst_data.aligned_ok),
							32'(want.aligned_ok));
					if (dst_data.bound_ok !== want.bound_ok)
						flag_mismatch("bound_ok", 32'(dst_data.bound_ok),
							32'(want.bound_ok));
					if (dst_data.first_found !== want.first_found)
						flag_mismatch("first_found", 32'(dst_data.first_found),
							32'(want.first_found));
					if (dst_data.first_reg !== want.first_reg)
						flag_mismatch("first_reg", 32'(dst_data.first_reg),
							32'(want.first_reg));
				end
			end
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				squeeze_left = SQUEEZE_CYCLES;
			end
			if (squeeze_left > 0) begin
				squeeze_left--;
				dst_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					hold = !calm && ($urandom_range(0, 99) < 35);
					if (!hold) run_left = $urandom_range(1, 30);
					else if ($urandom_range(0, 99) < 85) run_left = $urandom_range(1, 3);
					else run_left = $urandom_range(10, 40);
				end
				run_left--;
				dst_stall <= hold;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		src_word_t    pend [$];
		logic [383:0] bits;
		logic [383:0] grp;
		int           sent;
		int           phase;
		int           span;
		int           nw;
		int           sz;
		int           s;
		int           kind;
		int           k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIR_TAB[i]) begin
			if (DIR_TAB[i].is_cfg) write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
			else push_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].fixed_res, draw_gap());
		end
		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			k = $urandom_range(0, 3);
			if (k != 1) write_reg(CFG_SET_SIZE, 3'($urandom_range(0, 7)));
			if (k != 0) write_reg(CFG_MODE, 3'($urandom_range(0, 3)));
			calm <= ($urandom_range(0, 5) == 0);
			if (phase == 3) squeeze <= 1'b1;
			span = (phase == 3) ? 200 : $urandom_range(30, 150);
			repeat (span) begin
				if (pend.size() == 0) begin
					nw = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 8);
					sz = set_len();
					grp = (384'(1) << sz) - 384'(1);
					bits = '0;
					kind = $urandom_range(0, 99);
					if (kind < 8) begin
						bits = '0;
					end else if (kind < 30) begin
						bits = grp << (sz * $urandom_range(0, nw * 32 / sz - 1));
					end else if (kind < 50) begin
						// bias toward sets that straddle a word boundary
						if (nw > 1 && $urandom_range(0, 1) == 1)
							s = 32 * $urandom_range(1, nw - 1) - $urandom_range(1, sz);
						else
							s = $urandom_range(0, nw * 32 - sz);
						bits = grp << s;
					end else if (kind < 60) begin
						bits = grp << (nw * 32 - $urandom_range(1, sz));
					end else if (kind < 80) begin
						for (int g = 0; g < nw * 32 / sz; g++)
							if ($urandom_range(0, 2) == 0) bits |= grp << (g * sz);
					end else if (kind < 92) begin
						for (int i = 0; i < nw; i++) begin
							case ($urandom_range(0, 2))
								0: bits[i*32 +: 32] = $urandom();
								1: bits[i*32 +: 32] = $urandom() & $urandom() & $urandom();
								default: bits[i*32 +: 32] = '0;
							endcase
						end
					end else begin
						bits = grp << (sz * $urandom_range(0, nw * 32 / sz - 1));
						bits[(nw - 1) * 32 + 31] = 1'b1;
					end
					if (kind >= 8 && kind < 80 && $urandom_range(0, 9) == 0)
						bits[$urandom_range(0, nw * 32 - 1)] ^= 1'b1;
					bits &= (384'(1) << (nw * 32)) - 384'(1);
					for (int i = 0; i < nw; i++)
						pend.push_back('{mask_word: bits[i*32 +: 32], last_word: (i == nw - 1)});
				end
				push_word(pend.pop_front(), 1'b0, NO_RES, (phase == 3) ? 0 : draw_gap());
				sent++;
			end
			phase++;
		end
		src_valid <= 1'b0;
		while (mask_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* register_mask_set_engine.f */
hw/rtl/rmse_pkg.sv
hw/rtl/register_mask_set_engine.sv
tb/sv/register_mask_set_engine_tb.sv
